### hw/rtl/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared constants and round helpers for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1s_pkg;

  // Request function codes
  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // Storage geometry
  localparam int BLK_DEPTH   = 16;  // 32-bit words per 64-byte block
  localparam int CHAIN_DEPTH = 5;   // chaining words H0..H4
  localparam int WORD_W      = 32;

  // Byte written right after the message
  localparam logic [7:0] PAD_MARK = 8'h80;
  // Fill level at which the length field starts
  localparam logic [5:0] LEN_START = 6'd56;

  // Round constant groups
  localparam logic [1:0] PH_CH  = 2'd0;
  localparam logic [1:0] PH_P1  = 2'd1;
  localparam logic [1:0] PH_MAJ = 2'd2;
  localparam logic [1:0] PH_P2  = 2'd3;

  // Initial chaining value for one entry
  function automatic logic [31:0] sha1_iv(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      3'd4:    v = 32'hC3D2E1F0;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // New working word a of one round
  function automatic logic [31:0] sha1_t(input logic [1:0] ph,
                                         input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d,
                                         input logic [31:0] e, input logic [31:0] w);
    logic [31:0] f;
    logic [31:0] k;
    case (ph)
      PH_CH: begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end
      PH_P1: begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end
      PH_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end
      default: begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
    endcase
    return {a[26:0], a[31:27]} + f + e + k + w;
  endfunction

endpackage

### hw/rtl/sha1s_ram.sv
// ----------------------------------------------------------------------------
// sha1s_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha1s_ram #(
  parameter int WIDTH = sha1s_pkg::WORD_W,
  parameter int DEPTH = sha1s_pkg::BLK_DEPTH
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream, with block words and chaining words in RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): func = absorb takes data_byte as the
// next message byte; func = finish pads the message and emits its digest.
// Output channel (out_valid/out_stall): five digest_word requests, H0 first,
// word_last set on the fifth. A held request stays put while out_stall is high.
// Absorb bytes are taken one per cycle while in_stall is low. The 64th byte of
// a block starts a compression, with in_stall high throughout: S_LOAD streams
// the block RAM into the schedule window and the chain RAM into a..e, S_ROUND
// runs 80 rounds at one round per cycle, and S_UPD adds the result back into
// the chain RAM. No byte is taken until the compression is done.
// Finish pads one byte per cycle (up to 72 bytes, pausing on reaching the
// length field and during each compression), runs one or two compressions,
// then reads the five chain words, each through S_EMIT_RD and S_EMIT_WR
// (S_EMIT_WR waits while out_stall holds the output register). The block then
// returns to the initial chaining value and takes the next message.
// Reset (rst, synchronous) empties the block, clears the bit count and
// marks all chain entries as holding the initial value.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic        word_last
);
  import sha1s_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PAD     = 3'd1;
  localparam logic [2:0] S_LOAD    = 3'd2;
  localparam logic [2:0] S_ROUND   = 3'd3;
  localparam logic [2:0] S_UPD     = 3'd4;
  localparam logic [2:0] S_EMIT_RD = 3'd5;
  localparam logic [2:0] S_EMIT_WR = 3'd6;

  // Padding stages
  localparam logic [1:0] P_MARK = 2'd0;
  localparam logic [1:0] P_ZERO = 2'd1;
  localparam logic [1:0] P_LEN  = 2'd2;
  localparam logic [1:0] P_DONE = 2'd3;

  logic [2:0]  state;
  logic [6:0]  cnt;
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [4:0]  chain_valid;
  logic        finishing;
  logic [1:0]  pad_stage;
  logic [2:0]  len_idx;
  logic        rd_vld;
  logic [2:0]  rd_addr;

  logic [23:0] acc;
  logic [31:0] w [16];
  logic [31:0] r [5];

  logic        accept;
  logic        put_en;
  logic [7:0]  put_val;
  logic        out_free;

  logic        blk_we;
  logic        blk_re;
  logic [31:0] blk_rdata;
  logic        ch_we;
  logic [2:0]  ch_waddr;
  logic [31:0] ch_wdata;
  logic        ch_re;
  logic [31:0] ch_rdata;
  logic [31:0] chain_rd;
  logic [2:0]  upd_idx;
  logic [1:0]  phase;
  logic [31:0] t_new;
  logic [31:0] w_new;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign upd_idx  = 3'(cnt - 7'd1);

  // Byte source: absorbed data or generated padding
  always_comb begin
    put_en  = 1'b0;
    put_val = 8'h00;
    case (state)
      S_IDLE: begin
        if (accept && func == FUNC_ABSORB) begin
          put_en  = 1'b1;
          put_val = data_byte;
        end
      end
      S_PAD: begin
        case (pad_stage)
          P_MARK: begin
            put_en  = 1'b1;
            put_val = PAD_MARK;
          end
          P_ZERO: begin
            put_en  = (fill != LEN_START);
          end
          P_LEN: begin
            put_en  = 1'b1;
            put_val = message_bits[{~len_idx, 3'b000} +: 8];
          end
          default: begin
            put_en  = 1'b0;
          end
        endcase
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  // Block RAM: a word is written once its fourth byte arrives
  assign blk_we = put_en && (fill[1:0] == 2'd3);
  assign blk_re = (state == S_LOAD) && (cnt < 7'd16);

  sha1s_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BLK_DEPTH)
  ) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (fill[5:2]),
    .wdata ({acc, put_val}),
    .re    (blk_re),
    .raddr (cnt[3:0]),
    .rdata (blk_rdata)
  );

  // Chain RAM: read on load, read-add-write on update, read on emit
  assign ch_re = ((state == S_LOAD || state == S_UPD) && cnt < 7'd5) ||
                 (state == S_EMIT_RD);
  assign ch_we    = (state == S_UPD) && (cnt != 7'd0);
  assign ch_waddr = upd_idx;
  assign chain_rd = rd_vld ? ch_rdata : sha1_iv(rd_addr);
  assign ch_wdata = chain_rd + r[0];

  sha1s_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHAIN_DEPTH)
  ) u_chain_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (ch_re),
    .raddr (cnt[2:0]),
    .rdata (ch_rdata)
  );

  // Round function and schedule expansion
  always_comb begin
    if (cnt < 7'd20) begin
      phase = PH_CH;
    end else if (cnt < 7'd40) begin
      phase = PH_P1;
    end else if (cnt < 7'd60) begin
      phase = PH_MAJ;
    end else begin
      phase = PH_P2;
    end
  end

  assign t_new = sha1_t(phase, r[0], r[1], r[2], r[3], r[4], w[0]);
  assign w_new = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                  w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      fill         <= '0;
      message_bits <= '0;
      chain_valid  <= '0;
      finishing    <= 1'b0;
      pad_stage    <= P_MARK;
      len_idx      <= '0;
      rd_vld       <= 1'b0;
      rd_addr      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (put_en) begin
        fill <= fill + 6'd1;
      end
      if (ch_re) begin
        rd_vld  <= chain_valid[cnt[2:0]];
        rd_addr <= cnt[2:0];
      end
      // Output register: load a word when free, drop it once taken
      if (state == S_EMIT_WR && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (func == FUNC_ABSORB) begin
              message_bits <= message_bits + 64'd8;
              if (fill == 6'd63) begin
                state     <= S_LOAD;
                cnt       <= '0;
                finishing <= 1'b0;
              end
            end else begin
              state     <= S_PAD;
              pad_stage <= P_MARK;
              finishing <= 1'b1;
            end
          end
        end
        S_PAD: begin
          case (pad_stage)
            P_MARK: begin
              pad_stage <= P_ZERO;
              if (fill == 6'd63) begin
                state <= S_LOAD;
                cnt   <= '0;
              end
            end
            P_ZERO: begin
              if (fill == LEN_START) begin
                pad_stage <= P_LEN;
                len_idx   <= '0;
              end else if (fill == 6'd63) begin
                state <= S_LOAD;
                cnt   <= '0;
              end
            end
            P_LEN: begin
              len_idx <= len_idx + 3'd1;
              if (len_idx == 3'd7) begin
                pad_stage <= P_DONE;
                state     <= S_LOAD;
                cnt       <= '0;
              end
            end
            default: begin
              state <= S_LOAD;
              cnt   <= '0;
            end
          endcase
        end
        S_LOAD: begin
          if (cnt == 7'd16) begin
            state <= S_ROUND;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          if (cnt == 7'd79) begin
            state <= S_UPD;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_UPD: begin
          if (cnt != 7'd0) begin
            chain_valid[upd_idx] <= 1'b1;
          end
          if (cnt == 7'd5) begin
            cnt <= '0;
            if (!finishing) begin
              state <= S_IDLE;
            end else if (pad_stage == P_DONE) begin
              state <= S_EMIT_RD;
            end else begin
              state <= S_PAD;
            end
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (out_free) begin
            if (cnt == 7'd4) begin
              state        <= S_IDLE;
              cnt          <= '0;
              chain_valid  <= '0;
              fill         <= '0;
              message_bits <= '0;
              finishing    <= 1'b0;
              pad_stage    <= P_MARK;
            end else begin
              state <= S_EMIT_RD;
              cnt   <= cnt + 7'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: byte packer, schedule window, working words, output
  always_ff @(posedge clk) begin
    if (put_en) begin
      acc <= {acc[15:0], put_val};
    end
    if (state == S_LOAD && cnt != 7'd0) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= blk_rdata;
    end else if (state == S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
    if (state == S_LOAD && cnt != 7'd0 && cnt <= 7'd5) begin
      for (int i = 0; i < 4; i++) begin
        r[i] <= r[i+1];
      end
      r[4] <= chain_rd;
    end else if (state == S_ROUND) begin
      r[0] <= t_new;
      r[1] <= r[0];
      r[2] <= {r[1][1:0], r[1][31:2]};
      r[3] <= r[2];
      r[4] <= r[3];
    end else if (state == S_UPD && cnt != 7'd0) begin
      for (int i = 0; i < 4; i++) begin
        r[i] <= r[i+1];
      end
      r[4] <= r[4];
    end
    if (state == S_EMIT_WR && out_free) begin
      digest_word <= chain_rd;
      word_last   <= (cnt == 7'd4);
    end
  end

`ifndef SYNTHESIS
  // Round counter never passes the last round
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (cnt < 7'd80))
    else $error("round counter out of range");

  // A compression starts only on a full block
  a_load_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && cnt == 7'd0) |-> (fill == 6'd0))
    else $error("compression started on a partial block");

  // After an update every chain entry holds a written value
  a_chain_written: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && cnt == 7'd5) |=> (chain_valid == 5'h1f))
    else $error("chain update left an entry unwritten");

  // Length bytes occupy the last eight bytes of the block
  a_len_place: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD && pad_stage == P_LEN) |-> (fill[5:3] == 3'b111))
    else $error("length field misplaced");
`endif

endmodule

### tb/sha1_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// Self-checking bench for the SHA-1 stream hasher. A short table of directed
// requests comes first: known digests of the empty message and of "abc",
// repeated finish, and extreme byte values. Random messages of mixed length
// follow, including lengths that need one or two padding blocks. They run
// under changing sender idle and receiver stall patterns. Every digest word
// is compared with a typed-in known digest or with a behavioral SHA-1 that the bench keeps.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_tb;
  import sha1s_pkg::*;

  localparam int RAND_REQS    = 194;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_rsp_t;

  typedef struct {
    logic         f;
    logic [7:0]   b;
    bit           typed;
    logic [159:0] digest;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FUNC_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic        word_last;

  // Behavioral hash state
  logic [31:0] chain_h [5];
  logic [31:0] blk_w [16];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  digest_rsp_t digest_q[$];
  dir_row_t    dir_rows[$];

  int idle_by_phase  [4] = '{0, 87, 0, 12};
  int stall_by_phase [4] = '{0, 0, 87, 12};
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors      = 0;
  int n_req       = 0;
  int n_msgs      = 0;
  int n_words     = 0;
  int idle_cycles = 0;

  sha1_stream_hasher i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digest_word(digest_word),
    .word_last  (word_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Start a new message: initial chaining value, empty block, zero length
  function automatic void reset_chain();
    chain_h[0] = 32'h67452301;
    chain_h[1] = 32'hEFCDAB89;
    chain_h[2] = 32'h98BADCFE;
    chain_h[3] = 32'h10325476;
    chain_h[4] = 32'hC3D2E1F0;
    blk_fill   = 0;
    msg_bits   = 64'd0;
  endfunction

  // 80-round compression of the current block into the chain
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk_w[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Pack one byte big-endian; a full block is compressed at once
  function automatic void push_byte(input logic [7:0] v);
    int unsigned pos;
    pos = blk_fill;
    if (pos % 4 == 0) begin
      blk_w[pos / 4] = {v, 24'h000000};
    end else begin
      blk_w[pos / 4] |= 32'(v) << (8 * (3 - pos % 4));
    end
    pos++;
    if (pos == 64) begin
      compress_block();
      pos = 0;
    end
    blk_fill = pos;
  endfunction

  // Advance the hash for one accepted request; a finish queues five words
  function automatic void predict_request(input logic f, input logic [7:0] b,
                                          input bit typed, input logic [159:0] known);
    logic [63:0] len;
    if (f == FUNC_ABSORB) begin
      msg_bits += 64'd8;
      push_byte(b);
    end else begin
      len = msg_bits;
      push_byte(PAD_MARK);
      while (blk_fill != 32'(LEN_START)) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(len[63 - 8 * i -: 8]);
      for (int i = 0; i < 5; i++) begin
        digest_q.push_back(digest_rsp_t'{typed ? known[159 - 32 * i -: 32] : chain_h[i],
                                         i == 4});
      end
      reset_chain();
    end
  endfunction

  task automatic add_row(input logic f, input logic [7:0] b, input bit typed,
                         input logic [159:0] known);
    dir_rows.push_back('{f, b, typed, known});
  endtask

  // Present one request, with random idle ahead of it, and wait for acceptance
  task automatic send_req(input logic f, input logic [7:0] b, input bit typed,
                          input logic [159:0] known);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      func      <= 1'($urandom_range(1));
      data_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(f, b, typed, known);
    n_req++;
    if (f == FUNC_FINISH) n_msgs++;
  endtask

  // Hold the input off until every queued digest word has come out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Digest word checker
  always @(posedge clk) begin
    digest_rsp_t exp_rsp;
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest word: expected none, got %h last %b",
                 $time, digest_word, word_last);
      end else begin
        exp_rsp = digest_q.pop_front();
        n_words++;
        if (digest_word !== exp_rsp.word) begin
          errors++;
          $display("%0t: digest_word mismatch: expected %h, got %h",
                   $time, exp_rsp.word, digest_word);
        end
        if (word_last !== exp_rsp.last) begin
          errors++;
          $display("%0t: word_last mismatch: expected %b, got %b",
                   $time, exp_rsp.last, word_last);
        end
      end
    end
  end

  // Watchdog: cycles in a row with no request accepted on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("sha1_stream_hasher_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    int msg_idx;
    int n_dir;
    int ph;
    int cur_ph;
    reset_chain();
    for (int i = 0; i < 16; i++) blk_w[i] = 32'h0;

    // Directed table: known digests typed in, the rest left to the model
    add_row(FUNC_FINISH, 8'h00, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709);
    add_row(FUNC_FINISH, 8'hFF, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709);
    add_row(FUNC_ABSORB, 8'h61, 1'b0, '0);
    add_row(FUNC_ABSORB, 8'h62, 1'b0, '0);
    add_row(FUNC_ABSORB, 8'h63, 1'b0, '0);
    add_row(FUNC_FINISH, 8'h00, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d);
    add_row(FUNC_ABSORB, 8'h00, 1'b0, '0);
    add_row(FUNC_ABSORB, 8'hFF, 1'b0, '0);
    add_row(FUNC_FINISH, 8'hFF, 1'b0, '0);
    add_row(FUNC_ABSORB, 8'hFF, 1'b0, '0);
    add_row(FUNC_FINISH, 8'h00, 1'b0, '0);
    add_row(FUNC_ABSORB, 8'h80, 1'b0, '0);
    add_row(FUNC_ABSORB, 8'h7F, 1'b0, '0);
    add_row(FUNC_ABSORB, 8'h01, 1'b0, '0);
    add_row(FUNC_ABSORB, 8'hFE, 1'b0, '0);
    add_row(FUNC_FINISH, 8'hA5, 1'b0, '0);
    n_dir = dir_rows.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].f, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].digest);
    end

    // Random messages; the idle/stall phase follows the request count,
    // and the last phase always gets at least one message
    msg_idx = 0;
    cur_ph  = -1;
    while (n_req - n_dir < RAND_REQS || cur_ph < 3) begin
      ph = ((n_req - n_dir) * 4) / RAND_REQS;
      if (ph > 3) ph = 3;
      if (ph != cur_ph) begin
        drain_outputs();
        cur_ph         = ph;
        send_idle_pct  = idle_by_phase[ph];
        recv_stall_pct = stall_by_phase[ph];
      end
      // two-block padding, full block, then mostly short messages
      if (msg_idx == 0) len = 56;
      else if (msg_idx == 1) len = 64;
      else if ($urandom_range(7) == 0) len = 55 + 8 * $urandom_range(1);
      else len = $urandom_range(12);
      repeat (len) send_req(FUNC_ABSORB, 8'($urandom_range(255)), 1'b0, '0);
      send_req(FUNC_FINISH, 8'($urandom_range(255)), 1'b0, '0);
      msg_idx++;
    end

    drain_outputs();
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digest_q.size() != 0) begin
      errors++;
      $display("%0t: %0d digest words never arrived", $time, digest_q.size());
    end

    $display("Covered %0d requests in %0d messages (empty, abc, one- and two-block padding)",
             n_req, n_msgs);
    $display("under four idle/stall patterns; %0d digest words checked, %0d errors",
             n_words, errors);
    if (errors == 0) begin
      $display("sha1_stream_hasher_tb: PASS");
    end else begin
      $display("sha1_stream_hasher_tb: FAIL");
    end
    $finish;
  end

endmodule
